// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on a rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// implication checked in the next cycle
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: sv/spbo_pkg.sv
// ----------------------------------------------------------------------------
// spbo_pkg
// types and constants shared by the slow pwm / pulse burst output block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spbo_pkg;

    localparam int TIME_W  = 16;
    localparam int COUNT_W = 7;
    localparam int DUTY_W  = 7;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd3;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = 7'd100;

    // divide by 100 as multiply by ceil(2^30/100) and shift by 30
    localparam int PROD_W       = TIME_W + DUTY_W;
    localparam int RECIP_W      = 24;
    localparam int DIV_SHIFT    = 30;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;

    // input beat
    typedef struct packed {
        logic               opcode;
        logic [TIME_W-1:0]  pulse_ms;
        logic [COUNT_W-1:0] pulse_count;
    } item_in_t;

    // result beat
    typedef struct packed {
        logic pin_level;
        logic is_on;
        logic accepted;
    } item_out_t;

    localparam logic OPC_TICK  = 1'b0;
    localparam logic OPC_BURST = 1'b1;

    // classified work for the back end
    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_BURST = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               accepted;
        logic [TIME_W-1:0]  pulse_ms;
        logic [COUNT_W-1:0] pulse_count;
    } q_entry_t;

    // pwm settings handed from the front end to the back end
    typedef struct packed {
        logic              enable;
        logic              active_high;
        logic              duty_zero;
        logic              duty_full;
        logic              restart;
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
    } pwm_ctrl_t;

endpackage

// File: sv/spbo_front.sv
// ----------------------------------------------------------------------------
// spbo_front
// config registers, pwm phase time calculation and input classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbo_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spbo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spbo_pkg::TIME_W-1:0]         cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  spbo_pkg::item_in_t                  cmd_data,
    input  logic                                q_full,
    output logic                                q_push,
    output spbo_pkg::q_entry_t                  q_wdata,
    output spbo_pkg::pwm_ctrl_t                 pwm_ctrl
);
    import spbo_pkg::*;

    localparam logic [2:0] CALC_LEN = 3'd4;

    logic                enable_reg;
    logic                active_high_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [TIME_W-1:0]   period_reg;
    logic [2:0]          calc_cnt_reg;
    logic [2:0]          calc_cnt_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [TIME_W-1:0]   raw_reg;
    logic [TIME_W-1:0]   high_time_reg;
    logic [TIME_W-1:0]   low_time_reg;
    logic [DUTY_W-1:0]   eff_duty;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [TIME_W-1:0]   low_raw;
    logic                cfg_fire;
    logic                restart_req;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // writes that restart the pwm cycle
    always_comb
    begin
        restart_req = 1'b0;
        case (cfg_index)
            CFG_ENABLE:      restart_req = !(enable_reg && cfg_data[0]);
            CFG_ACTIVE_HIGH: restart_req = 1'b0;
            CFG_DUTY:        restart_req = 1'b1;
            CFG_PERIOD:      restart_req = 1'b1;
            default:         restart_req = 1'b0;
        endcase
    end

    // hold-off counter while phase times settle
    always_comb
    begin
        calc_cnt_next = calc_cnt_reg;
        if (cfg_fire && restart_req)
        begin
            calc_cnt_next = CALC_LEN;
        end
        else if (calc_cnt_reg != 3'd0)
        begin
            calc_cnt_next = calc_cnt_reg - 3'd1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            active_high_reg <= 1'b1;
            duty_reg        <= '0;
            period_reg      <= PERIOD_RESET;
            calc_cnt_reg    <= '0;
        end
        else
        begin
            calc_cnt_reg <= calc_cnt_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_ENABLE:      enable_reg      <= cfg_data[0];
                    CFG_ACTIVE_HIGH: active_high_reg <= cfg_data[0];
                    CFG_DUTY:        duty_reg        <= cfg_data[DUTY_W-1:0];
                    CFG_PERIOD:      period_reg      <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // phase time pipeline: period*duty, then /100, then clamp to at least one tick
    assign eff_duty = (duty_reg > DUTY_FULL) ? DUTY_FULL : duty_reg;
    assign scaled   = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(DIV100_RECIP);
    assign low_raw  = period_reg - raw_reg;

    always_ff @(posedge clk)
    begin
        prod_reg      <= PROD_W'(period_reg) * PROD_W'(eff_duty);
        raw_reg       <= scaled[DIV_SHIFT +: TIME_W];
        high_time_reg <= (raw_reg == '0) ? TIME_W'(1) : raw_reg;
        low_time_reg  <= (low_raw == '0) ? TIME_W'(1) : low_raw;
    end

    // settings seen by the back end
    assign pwm_ctrl.enable      = enable_reg;
    assign pwm_ctrl.active_high = active_high_reg;
    assign pwm_ctrl.duty_zero   = (eff_duty == '0);
    assign pwm_ctrl.duty_full   = (eff_duty == DUTY_FULL);
    assign pwm_ctrl.restart     = (calc_cnt_reg == 3'd1);
    assign pwm_ctrl.high_time   = high_time_reg;
    assign pwm_ctrl.low_time    = low_time_reg;

    // classify the incoming beat
    assign cmd_ready = !q_full && (calc_cnt_reg == 3'd0);
    assign q_push    = cmd_valid && cmd_ready;

    always_comb
    begin
        q_wdata.pulse_ms    = cmd_data.pulse_ms;
        q_wdata.pulse_count = cmd_data.pulse_count;
        q_wdata.accepted    = 1'b0;
        q_wdata.kind        = KIND_NOP;
        if (cmd_data.opcode == OPC_TICK)
        begin
            q_wdata.kind = KIND_TICK;
        end
        else if (enable_reg)
        begin
            q_wdata.accepted = 1'b1;
            if (cmd_data.pulse_count != '0)
            begin
                q_wdata.kind = KIND_BURST;
            end
        end
    end

endmodule

// File: sv/spbo_fifo.sv
// ----------------------------------------------------------------------------
// spbo_fifo
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbo_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spbo_pkg::q_entry_t  wdata,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output spbo_pkg::q_entry_t  rdata
);
    import spbo_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/spbo_back.sv
// ----------------------------------------------------------------------------
// spbo_back
// pwm and burst counters, pending slot and registered result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spbo_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spbo_pkg::pwm_ctrl_t  pwm_ctrl,
    input  logic                 q_valid,
    input  spbo_pkg::q_entry_t   q_rdata,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output spbo_pkg::item_out_t  res_data
);
    import spbo_pkg::*;

    logic               pwm_high_reg,      pwm_high_next;
    logic [TIME_W-1:0]  pwm_ticks_reg,     pwm_ticks_next;
    logic               burst_running_reg, burst_running_next;
    logic               burst_high_reg,    burst_high_next;
    logic [COUNT_W-1:0] burst_pulses_reg,  burst_pulses_next;
    logic [TIME_W-1:0]  burst_ticks_reg,   burst_ticks_next;
    logic [TIME_W-1:0]  burst_ms_reg,      burst_ms_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [TIME_W-1:0]  pending_ms_reg,    pending_ms_next;
    logic [COUNT_W-1:0] pending_count_reg, pending_count_next;
    logic               res_valid_reg;
    item_out_t          res_data_reg;
    item_out_t          res_data_next;
    logic               pwm_run;
    logic               pwm_on;
    logic               on;
    logic [COUNT_W-1:0] pulses_dec;
    logic [TIME_W-1:0]  half_ms;

    assign q_pop   = q_valid && (!res_valid_reg || res_ready);
    assign pwm_run = pwm_ctrl.enable && !pwm_ctrl.duty_zero && !pwm_ctrl.duty_full;
    assign half_ms = {1'b0, burst_ms_reg[TIME_W-1:1]};
    assign pulses_dec = (burst_pulses_reg != '0) ? burst_pulses_reg - COUNT_W'(1)
                                                 : burst_pulses_reg;

    // next state for one popped beat
    always_comb
    begin
        pwm_high_next      = pwm_high_reg;
        pwm_ticks_next     = pwm_ticks_reg;
        burst_running_next = burst_running_reg;
        burst_high_next    = burst_high_reg;
        burst_pulses_next  = burst_pulses_reg;
        burst_ticks_next   = burst_ticks_reg;
        burst_ms_next      = burst_ms_reg;
        pending_valid_next = pending_valid_reg;
        pending_ms_next    = pending_ms_reg;
        pending_count_next = pending_count_reg;

        if (q_pop)
        begin
            case (q_rdata.kind)
                KIND_TICK:
                begin
                    // pwm countdown
                    if (pwm_run)
                    begin
                        if (pwm_ticks_reg > TIME_W'(1))
                        begin
                            pwm_ticks_next = pwm_ticks_reg - TIME_W'(1);
                        end
                        else
                        begin
                            pwm_high_next  = !pwm_high_reg;
                            pwm_ticks_next = pwm_high_reg ? pwm_ctrl.low_time
                                                          : pwm_ctrl.high_time;
                        end
                    end
                    // burst countdown
                    if (burst_running_reg)
                    begin
                        if (burst_ticks_reg > TIME_W'(1))
                        begin
                            burst_ticks_next = burst_ticks_reg - TIME_W'(1);
                        end
                        else if (burst_high_reg)
                        begin
                            burst_high_next  = 1'b0;
                            burst_ticks_next = (half_ms == '0) ? TIME_W'(1) : half_ms;
                        end
                        else if (pulses_dec != '0)
                        begin
                            burst_pulses_next = pulses_dec;
                            burst_high_next   = 1'b1;
                            burst_ticks_next  = (burst_ms_reg == '0) ? TIME_W'(1)
                                                                     : burst_ms_reg;
                        end
                        else if (pending_valid_reg)
                        begin
                            // waiting command takes over on the same tick
                            pending_valid_next = 1'b0;
                            burst_running_next = 1'b1;
                            burst_high_next    = 1'b1;
                            burst_pulses_next  = pending_count_reg;
                            burst_ms_next      = pending_ms_reg;
                            burst_ticks_next   = (pending_ms_reg == '0) ? TIME_W'(1)
                                                                        : pending_ms_reg;
                        end
                        else
                        begin
                            burst_pulses_next  = pulses_dec;
                            burst_running_next = 1'b0;
                            burst_high_next    = 1'b0;
                            burst_ticks_next   = '0;
                        end
                    end
                end
                KIND_BURST:
                begin
                    if (!burst_running_reg)
                    begin
                        burst_running_next = 1'b1;
                        burst_high_next    = 1'b1;
                        burst_pulses_next  = q_rdata.pulse_count;
                        burst_ms_next      = q_rdata.pulse_ms;
                        burst_ticks_next   = (q_rdata.pulse_ms == '0) ? TIME_W'(1)
                                                                      : q_rdata.pulse_ms;
                    end
                    else if (!pending_valid_reg)
                    begin
                        pending_valid_next = 1'b1;
                        pending_ms_next    = q_rdata.pulse_ms;
                        pending_count_next = q_rdata.pulse_count;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output levels after the update
    always_comb
    begin
        if (!pwm_ctrl.enable || pwm_ctrl.duty_zero)
        begin
            pwm_on = 1'b0;
        end
        else if (pwm_ctrl.duty_full)
        begin
            pwm_on = 1'b1;
        end
        else
        begin
            pwm_on = pwm_high_next;
        end
        on = burst_running_next ? burst_high_next : pwm_on;
        res_data_next.is_on     = on;
        res_data_next.pin_level = pwm_ctrl.active_high ? on : !on;
        res_data_next.accepted  = q_rdata.accepted;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_high_reg      <= 1'b0;
            pwm_ticks_reg     <= '0;
            burst_running_reg <= 1'b0;
            burst_high_reg    <= 1'b0;
            burst_pulses_reg  <= '0;
            burst_ticks_reg   <= '0;
            burst_ms_reg      <= '0;
            pending_valid_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pwm_ctrl.restart)
            begin
                pwm_high_reg  <= pwm_ctrl.enable;
                pwm_ticks_reg <= pwm_ctrl.enable ? pwm_ctrl.high_time : '0;
            end
            else
            begin
                pwm_high_reg  <= pwm_high_next;
                pwm_ticks_reg <= pwm_ticks_next;
            end
            burst_running_reg <= burst_running_next;
            burst_high_reg    <= burst_high_next;
            burst_pulses_reg  <= burst_pulses_next;
            burst_ticks_reg   <= burst_ticks_next;
            burst_ms_reg      <= burst_ms_next;
            pending_valid_reg <= pending_valid_next;
            if (q_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pending_ms_reg    <= pending_ms_next;
        pending_count_reg <= pending_count_next;
        if (q_pop)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // a waiting command only exists behind a running burst
    `ASSERT_NOW(a_pending_needs_burst, clk, rst_n, !burst_running_reg, !pending_valid_reg)
    // a running burst always has a phase time and a pulse left
    `ASSERT_NOW(a_burst_ticks_live, clk, rst_n, burst_running_reg, burst_ticks_reg != '0)
    `ASSERT_NOW(a_burst_pulses_live, clk, rst_n, burst_running_reg, burst_pulses_reg != '0)
    // a popped beat always shows up as a result next cycle
    `ASSERT_NXT(a_pop_gives_result, clk, rst_n, q_pop, res_valid_reg)

endmodule

// File: sv/slow_pwm_and_pulse_burst_output.sv
// ----------------------------------------------------------------------------
// slow_pwm_and_pulse_burst_output
// millisecond-tick slow pwm with pulse bursts on one output pin
// ----------------------------------------------------------------------------
// a command beat is stored in the queue, then its result is registered in the back end
// throughput: one beat per cycle while res_ready does not stall and no config hold-off runs
// after a write to duty or period, or to enable unless it stays on, commands are held off
//   while the phase time multiply/divide pipeline settles
// reset: asynchronous active low; output off, bursts idle, queue empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slow_pwm_and_pulse_burst_output #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spbo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spbo_pkg::TIME_W-1:0]      cfg_data,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  spbo_pkg::item_in_t               cmd_data,
    output logic                             res_valid,
    input  logic                             res_ready,
    output spbo_pkg::item_out_t              res_data
);
    import spbo_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    q_entry_t   q_wdata;
    q_entry_t   q_rdata;
    pwm_ctrl_t  pwm_ctrl;

    // accept, classify and configure
    spbo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .pwm_ctrl  (pwm_ctrl)
    );

    // decoupling queue
    spbo_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    // counters and result beat
    spbo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pwm_ctrl  (pwm_ctrl),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// File: dv/slow_pwm_and_pulse_burst_output_test.sv
// ----------------------------------------------------------------------------
// slow_pwm_and_pulse_burst_output_test
// self-checking bench for the slow pwm / pulse burst output block
// ----------------------------------------------------------------------------
// every command beat is run through a local predictor of the pwm counters,
// the burst engine and its one-entry slot; each result beat is checked
// against the oldest prediction. directed cases come first, then random
// traffic in phases with different idle and stall mixes, then a long
// result-side hold-off that fills the block and stalls its input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slow_pwm_and_pulse_burst_output_test;
    import spbo_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_CHUNKS = 4;
    localparam int          CHUNK_BEATS  = 37;
    localparam int          MAX_PRINTS   = 40;
    localparam int unsigned PCT_FULL     = DUTY_FULL;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
    logic [TIME_W-1:0]    cfg_data  = '0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    item_in_t             cmd_data  = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    item_out_t            res_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int err_count      = 0;

    // predicted levels waiting for their result beat
    item_out_t levels_due[$];

    // register copies
    logic              m_enable      = 1'b0;
    logic              m_active_high = 1'b1;
    logic [DUTY_W-1:0] m_duty        = '0;
    logic [TIME_W-1:0] m_period      = PERIOD_RESET;

    // pwm counter and burst engine state
    logic               pwm_hi            = 1'b0;
    logic [TIME_W-1:0]  pwm_left          = '0;
    logic               burst_on          = 1'b0;
    logic               burst_hi          = 1'b0;
    logic [COUNT_W-1:0] burst_left_pulses = '0;
    logic [TIME_W-1:0]  burst_left_ticks  = '0;
    logic [TIME_W-1:0]  burst_ms          = '0;
    logic               slot_full         = 1'b0;
    logic [TIME_W-1:0]  slot_ms           = '0;
    logic [COUNT_W-1:0] slot_count        = '0;

    slow_pwm_and_pulse_burst_output i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int unsigned duty_clamped();
        return (m_duty > DUTY_FULL) ? PCT_FULL : int'(m_duty);
    endfunction

    function automatic logic [TIME_W-1:0] at_least_one(int unsigned v);
        return (v == 0) ? TIME_W'(1) : v[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] pwm_phase_len(logic high_side);
        int unsigned on_ticks;
        on_ticks = (int'(m_period) * duty_clamped()) / PCT_FULL;
        if (high_side)
            return at_least_one(on_ticks);
        return at_least_one(int'(m_period) - on_ticks);
    endfunction

    // cycle restarts at the head of the high phase
    function automatic void restart_pwm();
        pwm_hi   = m_enable;
        pwm_left = m_enable ? pwm_phase_len(1'b1) : '0;
    endfunction

    function automatic void load_burst(logic [TIME_W-1:0] ms, logic [COUNT_W-1:0] count);
        burst_on          = 1'b1;
        burst_hi          = 1'b1;
        burst_left_pulses = count;
        burst_ms          = ms;
        burst_left_ticks  = at_least_one(32'(ms));
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        logic was_on;
        case (idx)
            CFG_ENABLE:
            begin
                was_on   = m_enable;
                m_enable = data[0];
                if (!m_enable || !was_on)
                    restart_pwm();
            end
            CFG_ACTIVE_HIGH: m_active_high = data[0];
            CFG_DUTY:
            begin
                m_duty = data[DUTY_W-1:0];
                restart_pwm();
            end
            CFG_PERIOD:
            begin
                m_period = data;
                restart_pwm();
            end
            default: ;
        endcase
    endfunction

    function automatic item_out_t predict_levels(item_in_t beat);
        item_out_t   r;
        int unsigned d;
        logic        lvl;
        r = '0;
        d = duty_clamped();
        if (beat.opcode == OPC_TICK)
        begin
            // pwm keeps counting in the background, even under a burst
            if (m_enable && d != 0 && d != PCT_FULL)
            begin
                if (pwm_left > 1)
                    pwm_left = pwm_left - TIME_W'(1);
                else
                begin
                    pwm_hi   = ~pwm_hi;
                    pwm_left = pwm_phase_len(pwm_hi);
                end
            end
            // burst: high phase, low phase of half length, next pulse or end
            if (burst_on)
            begin
                if (burst_left_ticks > 1)
                    burst_left_ticks = burst_left_ticks - TIME_W'(1);
                else if (burst_hi)
                begin
                    burst_hi         = 1'b0;
                    burst_left_ticks = at_least_one(32'(burst_ms / 2));
                end
                else
                begin
                    if (burst_left_pulses > 0)
                        burst_left_pulses = burst_left_pulses - COUNT_W'(1);
                    if (burst_left_pulses > 0)
                    begin
                        burst_hi         = 1'b1;
                        burst_left_ticks = at_least_one(32'(burst_ms));
                    end
                    else
                    begin
                        burst_on         = 1'b0;
                        burst_hi         = 1'b0;
                        burst_left_ticks = '0;
                        // waiting command takes over on the same tick
                        if (slot_full)
                        begin
                            slot_full = 1'b0;
                            load_burst(slot_ms, slot_count);
                        end
                    end
                end
            end
        end
        else if (m_enable)
        begin
            r.accepted = 1'b1;
            if (beat.pulse_count != 0)
            begin
                if (!burst_on)
                    load_burst(beat.pulse_ms, beat.pulse_count);
                else if (!slot_full)
                begin
                    slot_full  = 1'b1;
                    slot_ms    = beat.pulse_ms;
                    slot_count = beat.pulse_count;
                end
            end
        end
        // a running burst wins over pwm
        if (burst_on)
            lvl = burst_hi;
        else
            lvl = m_enable && d != 0 && (d == PCT_FULL || pwm_hi);
        r.is_on     = lvl;
        r.pin_level = m_active_high ? lvl : ~lvl;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns error: %s", $time, what);
    endtask

    // ready: long hold-off when asked, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        item_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (levels_due.size() == 0)
                report_mismatch($sformatf("result beat with nothing due: %b", res_data));
            else
            begin
                want = levels_due.pop_front();
                if (res_data.pin_level !== want.pin_level)
                    report_mismatch($sformatf("pin_level %b, want %b",
                                              res_data.pin_level, want.pin_level));
                if (res_data.is_on !== want.is_on)
                    report_mismatch($sformatf("is_on %b, want %b",
                                              res_data.is_on, want.is_on));
                if (res_data.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              res_data.accepted, want.accepted));
            end
        end
    end

    // ------------------------------------------------------------------------
    // command and register side
    // ------------------------------------------------------------------------

    function automatic item_in_t beat_of(logic opc, logic [TIME_W-1:0] ms,
                                         logic [COUNT_W-1:0] count);
        item_in_t beat;
        beat.opcode      = opc;
        beat.pulse_ms    = ms;
        beat.pulse_count = count;
        return beat;
    endfunction

    task automatic send_item(item_in_t beat);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= beat;
        do
            @(posedge clk);
        while (!cmd_ready);
        levels_due.push_back(predict_levels(beat));
    endtask

    task automatic cmd_stop();
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    // registers change only once every result is back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        while (levels_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_setting(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic en, logic act, logic [DUTY_W-1:0] duty,
                             logic [TIME_W-1:0] period);
        write_reg(CFG_ENABLE, TIME_W'(en));
        write_reg(CFG_ACTIVE_HIGH, TIME_W'(act));
        write_reg(CFG_DUTY, TIME_W'(duty));
        write_reg(CFG_PERIOD, period);
    endtask

    // commands that would start or queue a burst stay short, bar a rare long train
    // of tiny pulses; the rest carry any payload since they are dropped or ignored
    function automatic item_in_t random_item();
        item_in_t beat;
        beat.opcode      = ($urandom_range(99) < 25) ? OPC_BURST : OPC_TICK;
        beat.pulse_ms    = TIME_W'($urandom);
        beat.pulse_count = COUNT_W'($urandom);
        if (beat.opcode == OPC_BURST && m_enable && !(burst_on && slot_full))
        begin
            if ($urandom_range(99) == 0)
            begin
                beat.pulse_ms    = TIME_W'($urandom_range(1, 0));
                beat.pulse_count = COUNT_W'($urandom_range(127, 100));
            end
            else
            begin
                beat.pulse_ms    = TIME_W'($urandom_range(6, 0));
                beat.pulse_count = COUNT_W'($urandom_range(4, 0));
            end
        end
        return beat;
    endfunction

    task automatic set_random_config();
        logic [DUTY_W-1:0] duty;
        logic [TIME_W-1:0] period;
        case ($urandom_range(5))
            0:       duty = '0;
            1:       duty = DUTY_FULL;
            2:       duty = '1;
            3:       duty = 7'd1;
            default: duty = DUTY_W'($urandom_range(99, 1));
        endcase
        case ($urandom_range(5))
            0:       period = TIME_W'($urandom_range(1, 0));
            1:       period = 16'd2;
            2:       period = '1;
            default: period = TIME_W'($urandom_range(20, 2));
        endcase
        if ($urandom_range(1))
            write_reg(CFG_ENABLE, TIME_W'($urandom_range(4) != 0));
        if ($urandom_range(1))
            write_reg(CFG_ACTIVE_HIGH, TIME_W'($urandom_range(1)));
        if ($urandom_range(1))
            write_reg(CFG_DUTY, TIME_W'(duty));
        if ($urandom_range(1))
            write_reg(CFG_PERIOD, period);
    endtask

    task automatic run_traffic_phase(int send_pct, int recv_pct, logic act,
                                     logic [DUTY_W-1:0] duty, logic [TIME_W-1:0] period);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_all(1'b1, act, duty, period);
        for (int c = 0; c < PHASE_CHUNKS; c++)
        begin
            if (c != 0)
                set_random_config();
            repeat (CHUNK_BEATS)
                send_item(random_item());
            cmd_stop();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // out of reset the block is disabled: commands are refused
    task automatic test_disabled_block();
        send_item(beat_of(OPC_TICK, '0, '0));
        send_item(beat_of(OPC_BURST, 16'd3, 7'd5));
        send_item(beat_of(OPC_BURST, '1, '1));
        cmd_stop();
    endtask

    // count of zero, start from idle, slot fill, drop on full slot, hand-over
    task automatic test_pwm_and_burst_queue();
        write_all(1'b1, 1'b0, 7'd50, 16'd4);
        repeat (2)
            send_item(beat_of(OPC_TICK, '0, '0));
        send_item(beat_of(OPC_BURST, 16'd9, 7'd0));
        send_item(beat_of(OPC_BURST, 16'd0, 7'd2));
        send_item(beat_of(OPC_BURST, 16'd2, 7'd1));
        send_item(beat_of(OPC_BURST, '1, '1));
        repeat (6)
            send_item(beat_of(OPC_TICK, '1, '1));
        cmd_stop();
    endtask

    // period below two and duty above full scale
    task automatic test_full_duty_and_zero_period();
        write_reg(CFG_PERIOD, 16'd0);
        write_reg(CFG_DUTY, TIME_W'(7'h7f));
        repeat (2)
            send_item(beat_of(OPC_TICK, '0, '0));
        cmd_stop();
    endtask

    // a running burst finishes after the block is disabled
    task automatic test_disable_under_burst();
        write_reg(CFG_DUTY, '0);
        send_item(beat_of(OPC_BURST, 16'd3, 7'd1));
        cmd_stop();
        write_reg(CFG_ENABLE, '0);
        repeat (4)
            send_item(beat_of(OPC_TICK, '0, '0));
        send_item(beat_of(OPC_BURST, 16'd5, 7'd2));
        cmd_stop();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 1'b1, 7'd50, 16'd7);
        run_traffic_phase(76, 0, 1'b0, 7'd33, 16'd2);
        run_traffic_phase(0, 76, 1'b1, DUTY_FULL, '1);
        run_traffic_phase(34, 34, 1'b0, 7'd1, 16'd3);
    endtask

    // result side holds off while commands keep coming
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_all(1'b1, 1'b1, 7'd50, 16'd5);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (CHUNK_BEATS)
            send_item(random_item());
        cmd_stop();
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        test_disabled_block();
        test_pwm_and_burst_queue();
        test_full_duty_and_zero_period();
        test_disable_under_burst();
        test_random_traffic();
        test_result_backpressure();

        // let every result come back, then watch for strays
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
